// File: hw/rtl/tppz_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and table functions for the torus point projector.
// No dependencies; imported by every other file of the block.

package tppz_pkg;

  localparam int DW        = 24;
  localparam int PW        = 2 * DW;
  localparam int DVW       = 19;
  localparam int QUOW      = 16;
  localparam int ZOOM_GAIN = 5500;
  localparam int Z_OFFSET  = 81920;
  localparam int NEAR_Z    = 8192;
  localparam int HALF_ONE  = 8192;
  localparam int RING_TWO  = 32768;
  localparam int FAR_DEPTH = 200;

  localparam logic [4:0] DIV_LAST  = 5'd28;
  localparam logic [3:0] LUM_MAX   = 4'd11;
  localparam logic [3:0] LUM_DIM   = 4'd10;
  localparam logic [6:0] CHAR_SPACE = 7'd32;

  localparam logic [2:0] REG_ANGLE_A  = 3'd0;
  localparam logic [2:0] REG_ANGLE_B  = 3'd1;
  localparam logic [2:0] REG_WIDTH    = 3'd2;
  localparam logic [2:0] REG_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_TITLE    = 3'd4;

  localparam logic CMD_CLEAR  = 1'b0;
  localparam logic CMD_RENDER = 1'b1;

  typedef logic signed [DW-1:0] word_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_DRAW  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [4:0] {
    P_X0, P_Z0, P_T1, P_Y1, P_T3, P_Z1, P_T5, P_X2, P_T7, P_Y2,
    P_U1, P_LA, P_U2, P_LB, P_LC, P_U3, P_U4, P_U5, P_LF,
    P_PXR, P_PYR, P_PX, P_PY, P_MX, P_MY, P_IDX
  } step_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  theta;
    logic [7:0]  phi;
    logic [15:0] clear_cell;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] cell_index;
    logic [3:0]  shade_level;
    logic [6:0]  char_code;
  } out_item_t;

  typedef struct packed {
    logic [7:0] angle_a;
    logic [7:0] angle_b;
    logic [8:0] width_cells;
    logic [7:0] height_cells;
    logic       title_row;
  } cfg_t;

  typedef struct packed {
    logic  load;
    logic  step_en;
    step_t step;
    logic  div_start;
    logic  clr;
    logic  mem_rd;
    logic  cmp;
    logic  out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

  localparam logic [14:0] QSINE [65] = '{
    15'd0, 15'd402, 15'd803, 15'd1205, 15'd1605, 15'd2005, 15'd2404, 15'd2801,
    15'd3196, 15'd3589, 15'd3980, 15'd4369, 15'd4755, 15'd5139, 15'd5519,
    15'd5896, 15'd6269, 15'd6639, 15'd7004, 15'd7366, 15'd7723, 15'd8075,
    15'd8423, 15'd8765, 15'd9102, 15'd9434, 15'd9759, 15'd10079, 15'd10393,
    15'd10701, 15'd11002, 15'd11297, 15'd11585, 15'd11866, 15'd12139, 15'd12406,
    15'd12664, 15'd12914, 15'd13156, 15'd13389, 15'd13614, 15'd13830, 15'd14036,
    15'd14234, 15'd14422, 15'd14601, 15'd14770, 15'd14929, 15'd15079, 15'd15219,
    15'd15349, 15'd15469, 15'd15579, 15'd15678, 15'd15767, 15'd15846, 15'd15913,
    15'd15970, 15'd16017, 15'd16053, 15'd16078, 15'd16093, 15'd16097, 15'd16091,
    15'd16384
  };

  localparam logic [6:0] RAMP [12] = '{
    7'd46, 7'd44, 7'd45, 7'd126, 7'd58, 7'd59, 7'd61, 7'd33, 7'd42, 7'd35,
    7'd36, 7'd64
  };

  function automatic word_t sine_of(input logic [7:0] a);
    logic [6:0] k;
    word_t      v;
    word_t      w;
    word_t      r;
    k = {1'b0, a[5:0]};
    v = word_t'(QSINE[k]);
    w = word_t'(QSINE[7'd64 - k]);
    unique case (a[7:6])
      2'd0: r = v;
      2'd1: r = w;
      2'd2: r = -v;
      default: r = -w;
    endcase
    return r;
  endfunction

  function automatic word_t cosine_of(input logic [7:0] a);
    return sine_of(a + 8'd64);
  endfunction

endpackage

// File: hw/rtl/tppz_div.sv
`timescale 1ns / 1ps
// Restoring divider that forms the perspective reciprocal 2^28 / z, one bit a cycle.
// Depends on tppz_pkg.

module tppz_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [tppz_pkg::DVW-1:0] divisor,
  output logic                    done,
  output logic [tppz_pkg::QUOW-1:0] quotient
);
  import tppz_pkg::*;

  logic            busy_r;
  logic            done_r;
  logic [4:0]      cnt_r;
  logic [DVW-1:0]  rem_r;
  logic [DVW-1:0]  dvs_r;
  logic [QUOW-1:0] quo_r;
  logic [DVW:0]    sh;
  logic            ge;
  logic [DVW-1:0]  rem_nxt;

  always_comb begin
    sh      = {rem_r, (cnt_r == DIV_LAST)};
    ge      = sh >= {1'b0, dvs_r};
    rem_nxt = ge ? DVW'(sh - {1'b0, dvs_r}) : sh[DVW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= DIV_LAST;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[QUOW-2:0], ge};
      if (cnt_r == 5'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r - 5'd1;
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: hw/rtl/tppz_dp.sv
`timescale 1ns / 1ps
// Datapath: sine tables, one shared Q14 multiplier, the reciprocal divider,
// the depth memory and the result register. Depends on tppz_pkg and tppz_div.

module tppz_dp #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_HEIGHT  = 192,
  parameter int DEPTH_CELLS = 49152
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tppz_pkg::cfg_t       cfg,
  input  tppz_pkg::in_item_t   in_item,
  input  tppz_pkg::ctrl_cmd_t  cmd,
  output tppz_pkg::dp_stat_t   stat,
  output tppz_pkg::out_item_t  out_item
);
  import tppz_pkg::*;

  localparam int AW = $clog2(DEPTH_CELLS);

  in_item_t  item_r;
  word_t     sa_r, ca_r, sb_r, cb_r, st_r, ct_r, sp_r, cp_r;
  word_t     x0_r, z0_r, t_r, y1_r, z1_r, x2_r, y2_r, u_r, l_r, px_r, py_r;
  logic [DW-1:0] idx_r;
  logic      geo_ok_r;
  logic      z_ok_r;
  logic [15:0] rd_r;
  out_item_t res_r;
  out_item_t out_r;
  logic [15:0] depth_r [DEPTH_CELLS];

  logic [8:0]  w;
  logic [7:0]  h;
  logic        tcut;
  logic [7:0]  rh;
  logic [7:0]  row0;
  logic [7:0]  cx;
  logic [8:0]  cy;
  logic [10:0] w3;
  logic [9:0]  rh3;
  logic [7:0]  w38;
  logic [6:0]  rh38;

  word_t       ringx, ma, mb, qv, mt, td, xp, yp, zt, lt, lsh;
  logic signed [PW-1:0] prod;
  logic        geo_ok;
  logic        div_done;
  logic [QUOW-1:0] inv;
  logic [15:0] zval;
  logic        idx_in;
  logic        pass;
  logic [3:0]  lum;
  logic        clr_in;
  logic        we;
  logic [AW-1:0] waddr;
  logic [15:0] wdata;

  always_comb begin
    w    = ({2'b0, cfg.width_cells} > 11'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : cfg.width_cells;
    h    = ({3'b0, cfg.height_cells} > 11'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT)
                                                         : cfg.height_cells;
    tcut = cfg.title_row && (h > 8'd3);
    rh   = tcut ? h - 8'd3 : h;
    row0 = tcut ? 8'd1 : 8'd0;
    cx   = w[8:1];
    cy   = {1'b0, row0} + {2'b0, rh[7:1]};
    w3   = {2'b0, w} * 11'd3;
    rh3  = {2'b0, rh} * 10'd3;
    w38  = w3[10:3];
    rh38 = rh3[9:3];
  end

  always_comb begin
    ringx = word_t'(RING_TWO) + ct_r;
    ma    = '0;
    mb    = '0;
    unique case (cmd.step)
      P_X0:  begin ma = ringx; mb = cp_r; end
      P_Z0:  begin ma = ringx; mb = sp_r; end
      P_T1:  begin ma = st_r;  mb = ca_r; end
      P_Y1:  begin ma = z0_r;  mb = sa_r; end
      P_T3:  begin ma = st_r;  mb = sa_r; end
      P_Z1:  begin ma = z0_r;  mb = ca_r; end
      P_T5:  begin ma = x0_r;  mb = cb_r; end
      P_X2:  begin ma = y1_r;  mb = sb_r; end
      P_T7:  begin ma = x0_r;  mb = sb_r; end
      P_Y2:  begin ma = y1_r;  mb = cb_r; end
      P_U1:  begin ma = ct_r;  mb = sb_r; end
      P_LA:  begin ma = cp_r;  mb = u_r;  end
      P_U2:  begin ma = ct_r;  mb = sp_r; end
      P_LB:  begin ma = ca_r;  mb = u_r;  end
      P_LC:  begin ma = sa_r;  mb = st_r; end
      P_U3:  begin ma = sa_r;  mb = sp_r; end
      P_U4:  begin ma = ct_r;  mb = u_r;  end
      P_U5:  begin ma = ca_r;  mb = st_r; end
      P_LF:  begin ma = cb_r;  mb = u_r;  end
      P_PXR: begin ma = x2_r;  mb = word_t'(inv); end
      P_PYR: begin ma = y2_r;  mb = word_t'(inv); end
      P_PX:  begin ma = px_r;  mb = word_t'(ZOOM_GAIN); end
      P_PY:  begin ma = py_r;  mb = word_t'(ZOOM_GAIN); end
      P_MX:  begin ma = px_r;  mb = word_t'(w38); end
      P_MY:  begin ma = py_r;  mb = word_t'(rh38); end
      P_IDX: begin ma = yp;    mb = word_t'(w); end
      default: begin ma = '0; mb = '0; end
    endcase
    prod = ma * mb;
    qv   = prod[DW+13:14];
    mt   = prod[DW-1:0];
    td   = (mt + (mt[DW-1] ? word_t'(31) : word_t'(0))) >>> 5;
    xp   = word_t'(cx) + px_r;
    yp   = word_t'(cy) - py_r;
    geo_ok = !xp[DW-1] && (xp < word_t'(w)) && (yp >= word_t'(row0))
             && (yp < word_t'({1'b0, row0} + {1'b0, rh}));
    zt   = z1_r + word_t'(Z_OFFSET);
  end

  tppz_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .divisor  (zt[DVW-1:0]),
    .done     (div_done),
    .quotient (inv)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
      sa_r   <= sine_of(cfg.angle_a);
      ca_r   <= cosine_of(cfg.angle_a);
      sb_r   <= sine_of(cfg.angle_b);
      cb_r   <= cosine_of(cfg.angle_b);
      st_r   <= sine_of(in_item.theta);
      ct_r   <= cosine_of(in_item.theta);
      sp_r   <= sine_of(in_item.phi);
      cp_r   <= cosine_of(in_item.phi);
    end
    if (cmd.div_start) begin
      z_ok_r <= zt > word_t'(NEAR_Z);
    end
    if (cmd.step_en) begin
      unique case (cmd.step)
        P_X0:  x0_r <= qv;
        P_Z0:  z0_r <= qv;
        P_T1:  t_r  <= qv;
        P_Y1:  y1_r <= t_r - qv;
        P_T3:  t_r  <= qv;
        P_Z1:  z1_r <= t_r + qv;
        P_T5:  t_r  <= qv;
        P_X2:  x2_r <= t_r - qv;
        P_T7:  t_r  <= qv;
        P_Y2:  y2_r <= t_r + qv;
        P_U1:  u_r  <= qv;
        P_LA:  l_r  <= qv;
        P_U2:  u_r  <= qv;
        P_LB:  l_r  <= l_r - qv;
        P_LC:  l_r  <= l_r - qv;
        P_U3:  u_r  <= qv;
        P_U4:  u_r  <= qv;
        P_U5:  u_r  <= qv - u_r;
        P_LF:  l_r  <= l_r + qv;
        P_PXR: px_r <= prod[DW+20:21];
        P_PYR: py_r <= prod[DW+21:22];
        P_PX:  px_r <= qv;
        P_PY:  py_r <= qv;
        P_MX:  px_r <= td;
        P_MY:  py_r <= td;
        P_IDX: begin
          idx_r    <= DW'(mt + xp);
          geo_ok_r <= geo_ok;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    zval   = {4'b0, inv[15:4]};
    idx_in = 32'(idx_r) < 32'(DEPTH_CELLS);
    lt     = l_r + word_t'(HALF_ONE);
    lsh    = lt >>> 10;
    pass   = z_ok_r && geo_ok_r && idx_in && (lt > word_t'(0)) && (zval > rd_r);
    lum    = (lsh > word_t'(LUM_MAX)) ? LUM_MAX : lsh[3:0];
    if ((lum == LUM_MAX) && (zval >= 16'(FAR_DEPTH))) begin
      lum = LUM_DIM;
    end
    clr_in = 32'(item_r.clear_cell) < 32'(DEPTH_CELLS);
    we     = (cmd.clr && clr_in) || (cmd.cmp && pass);
    waddr  = cmd.clr ? AW'(item_r.clear_cell) : AW'(idx_r);
    wdata  = cmd.clr ? 16'd0 : zval;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      depth_r[waddr] <= wdata;
    end
    if (cmd.mem_rd) begin
      rd_r <= depth_r[AW'(idx_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      res_r.kind        <= clr_in ? KIND_CLEAR : KIND_NONE;
      res_r.cell_index  <= clr_in ? item_r.clear_cell : 16'd0;
      res_r.shade_level <= 4'd0;
      res_r.char_code   <= CHAR_SPACE;
    end else if (cmd.cmp) begin
      res_r.kind        <= pass ? KIND_DRAW : KIND_NONE;
      res_r.cell_index  <= pass ? idx_r[15:0] : 16'd0;
      res_r.shade_level <= pass ? lum + 4'd1 : 4'd0;
      res_r.char_code   <= pass ? RAMP[lum] : CHAR_SPACE;
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign stat.div_done = div_done;
  assign out_item      = out_r;

endmodule

// File: hw/rtl/tppz_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences the multiply steps, divider, memory access and result hand-off.
// Depends on tppz_pkg.

module tppz_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_cmd,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  tppz_pkg::dp_stat_t  stat,
  output tppz_pkg::ctrl_cmd_t cmd
);
  import tppz_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CLR   = 7'b0000010,
    ST_RUN   = 7'b0000100,
    ST_DWAIT = 7'b0001000,
    ST_RD    = 7'b0010000,
    ST_CMP   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.step      = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = P_X0;
          state_nxt = (in_cmd == CMD_RENDER) ? ST_RUN : ST_CLR;
        end
      end
      ST_CLR: begin
        cmd.clr   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_RUN: begin
        cmd.step_en   = 1'b1;
        cmd.div_start = (step_r == P_T5);
        if (step_r == P_LF) begin
          step_nxt  = P_PXR;
          state_nxt = ST_DWAIT;
        end else if (step_r == P_IDX) begin
          state_nxt = ST_RD;
        end else begin
          step_nxt = step_t'(step_r + 5'd1);
        end
      end
      ST_DWAIT: begin
        if (stat.div_done) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= P_X0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: hw/rtl/torus_point_project_zbuffer.sv
`timescale 1ns / 1ps
// Top level of the torus point projector: configuration registers and wiring.
// Depends on tppz_pkg, tppz_ctrl and tppz_dp.

// A transaction is accepted only in the idle state, once the previous one has
// been handed to the result register. The render time is set by the reciprocal
// divider, which starts as soon as the depth is known and runs beside the
// remaining rotation and shading multiplies on the single shared multiplier,
// and then by the projection steps and the depth memory read, compare and
// write. The result register lets a new transaction be accepted while an
// earlier result still waits. The depth memory is not cleared at reset: every
// cell must be cleared before it is rendered to.

module torus_point_project_zbuffer #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_HEIGHT  = 192,
  parameter int DEPTH_CELLS = 49152
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tppz_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output tppz_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import tppz_pkg::*;

  cfg_t      cfg_r;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.angle_a      <= 8'd0;
      cfg_r.angle_b      <= 8'd0;
      cfg_r.width_cells  <= 9'd256;
      cfg_r.height_cells <= 8'd192;
      cfg_r.title_row    <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_ANGLE_A: cfg_r.angle_a      <= pwdata[7:0];
        REG_ANGLE_B: cfg_r.angle_b      <= pwdata[7:0];
        REG_WIDTH:   cfg_r.width_cells  <= pwdata[8:0];
        REG_HEIGHT:  cfg_r.height_cells <= pwdata[7:0];
        REG_TITLE:   cfg_r.title_row    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_ANGLE_A: prdata = {24'd0, cfg_r.angle_a};
      REG_ANGLE_B: prdata = {24'd0, cfg_r.angle_b};
      REG_WIDTH:   prdata = {23'd0, cfg_r.width_cells};
      REG_HEIGHT:  prdata = {24'd0, cfg_r.height_cells};
      REG_TITLE:   prdata = {31'd0, cfg_r.title_row};
      default:     prdata = 32'd0;
    endcase
  end

  tppz_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_item.cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tppz_dp #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .DEPTH_CELLS (DEPTH_CELLS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule
